@@ rtl/ssk_pkg.sv @@
// Shared types and character codes for the statement/block skip scanner.
`timescale 1ns / 1ps
`default_nettype none

package ssk_pkg;

	typedef enum logic [2:0] {
		LEX_NORMAL,
		LEX_SLASH,
		LEX_LINE,
		LEX_BLOCK,
		LEX_STAR
	} lex_mode_t;

	typedef enum logic [1:0] {
		QUOTE_NONE,
		QUOTE_DOUBLE,
		QUOTE_SINGLE
	} quote_t;

	localparam logic [1:0] STATUS_BRACE     = 2'd0;
	localparam logic [1:0] STATUS_SEMI      = 2'd1;
	localparam logic [1:0] STATUS_EARLY_END = 2'd2;

	localparam logic [7:0] CHR_EOF     = 8'h00;
	localparam logic [7:0] CHR_SUB     = 8'h1A;
	localparam logic [7:0] CHR_NL      = 8'h0A;
	localparam logic [7:0] CHR_DQUOTE  = 8'h22;
	localparam logic [7:0] CHR_SQUOTE  = 8'h27;
	localparam logic [7:0] CHR_LPAREN  = 8'h28;
	localparam logic [7:0] CHR_RPAREN  = 8'h29;
	localparam logic [7:0] CHR_STAR    = 8'h2A;
	localparam logic [7:0] CHR_SLASH   = 8'h2F;
	localparam logic [7:0] CHR_SEMI    = 8'h3B;
	localparam logic [7:0] CHR_LBRACE  = 8'h7B;
	localparam logic [7:0] CHR_RBRACE  = 8'h7D;

	typedef struct packed {
		logic       report;
		logic [1:0] status;
	} scan_result_t;

endpackage

`default_nettype wire

@@ rtl/ssk_scan.sv @@
// Per-character next-state and report logic of the skip scanner.
`timescale 1ns / 1ps
`default_nettype none

module ssk_scan
	import ssk_pkg::*;
#(
	parameter int DEPTH_BITS = 16
) (
	input  wire logic [7:0]                   char_in,
	input  wire lex_mode_t                    lex_cur,
	input  wire quote_t                       quote_cur,
	input  wire logic [DEPTH_BITS-1:0]        paren_cur,
	input  wire logic signed [DEPTH_BITS-1:0] brace_cur,
	output lex_mode_t                         lex_nxt,
	output quote_t                            quote_nxt,
	output logic [DEPTH_BITS-1:0]             paren_nxt,
	output logic signed [DEPTH_BITS-1:0]      brace_nxt,
	output scan_result_t                      result
);

	localparam logic [DEPTH_BITS-1:0] PAREN_MAX = {DEPTH_BITS{1'b1}};
	localparam logic signed [DEPTH_BITS-1:0] BRACE_MAX = {1'b0, {(DEPTH_BITS-1){1'b1}}};
	localparam logic signed [DEPTH_BITS-1:0] BRACE_MIN = {1'b1, {(DEPTH_BITS-1){1'b0}}};

	logic quoted;
	logic normal;
	logic end_char;
	logic signed [DEPTH_BITS-1:0] brace_dec;

	assign quoted    = (quote_cur != QUOTE_NONE);
	assign end_char  = (char_in == CHR_EOF) || (char_in == CHR_SUB);
	assign brace_dec = (brace_cur != BRACE_MIN) ? brace_cur - 1'b1 : brace_cur;

	always_comb begin
		lex_nxt   = lex_cur;
		quote_nxt = quote_cur;
		paren_nxt = paren_cur;
		brace_nxt = brace_cur;
		result    = '0;
		normal    = 1'b0;

		case (lex_cur)
			LEX_SLASH: begin
				if (char_in == CHR_SLASH) begin
					lex_nxt = LEX_LINE;
				end else if (char_in == CHR_STAR) begin
					lex_nxt = LEX_BLOCK;
				end else begin
					// lone slash is dropped, this char scans normally
					lex_nxt = LEX_NORMAL;
					normal  = 1'b1;
				end
			end
			LEX_LINE: begin
				if (char_in == CHR_NL) lex_nxt = LEX_NORMAL;
			end
			LEX_BLOCK: begin
				if (char_in == CHR_STAR) lex_nxt = LEX_STAR;
			end
			LEX_STAR: begin
				if (char_in == CHR_SLASH) lex_nxt = LEX_NORMAL;
				else if (char_in != CHR_STAR) lex_nxt = LEX_BLOCK;
			end
			default: begin
				lex_nxt = LEX_NORMAL;
				normal  = 1'b1;
			end
		endcase

		if (normal) begin
			case (char_in)
				CHR_SLASH: lex_nxt = LEX_SLASH;
				CHR_LBRACE: begin
					if (!quoted && brace_cur != BRACE_MAX) brace_nxt = brace_cur + 1'b1;
				end
				CHR_RBRACE: begin
					if (!quoted) begin
						brace_nxt = brace_dec;
						if (brace_dec == '0) begin
							result.report = 1'b1;
							result.status = STATUS_BRACE;
						end
					end
				end
				CHR_DQUOTE: begin
					if (!quoted) quote_nxt = QUOTE_DOUBLE;
					else if (quote_cur == QUOTE_DOUBLE) quote_nxt = QUOTE_NONE;
				end
				CHR_SQUOTE: begin
					if (!quoted) quote_nxt = QUOTE_SINGLE;
					else if (quote_cur == QUOTE_SINGLE) quote_nxt = QUOTE_NONE;
				end
				CHR_LPAREN: begin
					if (!quoted && paren_cur != PAREN_MAX) paren_nxt = paren_cur + 1'b1;
				end
				CHR_RPAREN: begin
					if (!quoted && paren_cur != '0) paren_nxt = paren_cur - 1'b1;
				end
				CHR_SEMI: begin
					if (!quoted && paren_cur == '0 && brace_cur == '0) begin
						result.report = 1'b1;
						result.status = STATUS_SEMI;
					end
				end
				default: ;
			endcase
		end

		// end of input wins in every mode
		if (end_char) begin
			result.report = 1'b1;
			result.status = STATUS_EARLY_END;
		end

		if (result.report) begin
			lex_nxt   = LEX_NORMAL;
			quote_nxt = QUOTE_NONE;
			paren_nxt = '0;
			brace_nxt = '0;
		end
	end

endmodule

`default_nettype wire

@@ rtl/statement_block_skip_scanner_core.sv @@
// Top level of the statement/block skip scanner: input register, scan step, result register.
// A report appears on m_axis from the result register once its character has passed
// the input register and the scan step.
// Throughput: one character per cycle if not stalled; the scan state updates in one step.
// A pending result holds the input register only while a full result register is not taken.
// Reset (arst_n low, asynchronous): scan state cleared, both registers empty.
`timescale 1ns / 1ps
`default_nettype none

module statement_block_skip_scanner_core
	import ssk_pkg::*;
#(
	parameter int DEPTH_BITS = 16
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_axis_tvalid,
	output logic            s_axis_tready,
	input  wire logic [7:0] s_axis_tdata,   // [7:0] source_byte
	output logic            m_axis_tvalid,
	input  wire logic       m_axis_tready,
	output logic [7:0]      m_axis_tdata    // [1:0] end_status, [7:2] zero
);

	lex_mode_t                    lex_q, lex_nxt;
	quote_t                       quote_q, quote_nxt;
	logic [DEPTH_BITS-1:0]        paren_q, paren_nxt;
	logic signed [DEPTH_BITS-1:0] brace_q, brace_nxt;
	scan_result_t                 result;

	logic       valid_s1;
	logic [7:0] char_s1;
	logic       out_valid_q;
	logic [1:0] status_q;
	logic       advance;

	ssk_scan #(
		.DEPTH_BITS(DEPTH_BITS)
	) u_scan (
		.char_in  (char_s1),
		.lex_cur  (lex_q),
		.quote_cur(quote_q),
		.paren_cur(paren_q),
		.brace_cur(brace_q),
		.lex_nxt  (lex_nxt),
		.quote_nxt(quote_nxt),
		.paren_nxt(paren_nxt),
		.brace_nxt(brace_nxt),
		.result   (result)
	);

	// a char without a report never waits on the output side
	assign advance       = valid_s1 && (!result.report || !out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'b0, status_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			lex_q       <= LEX_NORMAL;
			quote_q     <= QUOTE_NONE;
			paren_q     <= '0;
			brace_q     <= '0;
		end else begin
			if (s_axis_tready) valid_s1 <= s_axis_tvalid;
			if (advance) begin
				lex_q   <= lex_nxt;
				quote_q <= quote_nxt;
				paren_q <= paren_nxt;
				brace_q <= brace_nxt;
			end
			if (advance && result.report) out_valid_q <= 1'b1;
			else if (m_axis_tready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready) char_s1 <= s_axis_tdata;
		if (advance && result.report) status_q <= result.status;
	end

endmodule

`default_nettype wire

@@ rtl/ssk_checker.sv @@
// Port-level checks for the skip scanner, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module ssk_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       s_axis_tvalid,
	input wire logic       s_axis_tready,
	input wire logic [7:0] s_axis_tdata,
	input wire logic       m_axis_tvalid,
	input wire logic       m_axis_tready,
	input wire logic [7:0] m_axis_tdata
);

	// input side only stalls behind a full, blocked result register
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
		else $error("input stalled without a blocked result");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[7:2] == 6'b0 && m_axis_tdata[1:0] != 2'd3))
		else $error("bad end_status code");

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
		else $error("result dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// input data is only inspected through the handshake
	a_in_known: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |-> !$isunknown(s_axis_tdata))
		else $error("unknown item accepted");

endmodule

bind statement_block_skip_scanner_core ssk_checker u_ssk_checker (.*);

`default_nettype wire
